@@ design/pft_pkg.sv @@
// Package for the pulse flow totalizer: event codes, display mode codes,
// register indexes, reset values and fixed field widths.
// No dependencies.
package pft_pkg;

   // Event codes carried by req_cmd; code seven is unused and ignored.
   typedef enum logic [2:0] {
      CMD_PULSE    = 3'd0,
      CMD_TICK     = 3'd1,
      CMD_START    = 3'd2,
      CMD_STOP     = 3'd3,
      CMD_CLEAR    = 3'd4,
      CMD_SET_MODE = 3'd5,
      CMD_LOAD     = 3'd6
   } cmd_type;

   // Display mode codes; code three is stored as given and shows nothing.
   localparam logic [1:0] MODE_OFF   = 2'd0;
   localparam logic [1:0] MODE_RATE  = 2'd1;
   localparam logic [1:0] MODE_TOTAL = 2'd2;

   // Register indexes on the csr port.
   localparam logic [1:0] CSR_SAVE_THRESHOLD = 2'd0;
   localparam logic [1:0] CSR_SAVE_PERIOD    = 2'd1;
   localparam logic [1:0] CSR_UPDATE_PERIOD  = 2'd2;
   localparam logic [1:0] CSR_TOGGLE_PERIOD  = 2'd3;

   // Register reset values.
   localparam logic [15:0] SAVE_THRESHOLD_RST = 16'd50;
   localparam logic [7:0]  SAVE_PERIOD_RST    = 8'd10;
   localparam logic [7:0]  UPDATE_PERIOD_RST  = 8'd1;
   localparam logic [7:0]  TOGGLE_PERIOD_RST  = 8'd3;

   // Start delay armed by a start, in ticks.
   localparam logic [1:0]  START_DELAY_TICKS = 2'd2;

   // Fixed widths.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int TALLY_W    = 16;
   localparam int TOTAL_W    = 32;
   localparam int PERIOD_W   = 8;
   localparam int DISP_W     = 28;

   // Binary to BCD conversion: bits shifted in per pipeline stage.
   localparam int BITS_PER_STAGE = 4;
   localparam int CONV_STAGES    = TOTAL_W / BITS_PER_STAGE;

   // Default number of BCD digits produced before packing to the display field.
   localparam int DIGITS_DEF = 7;

endpackage

@@ design/pulse_flow_totalizer.sv @@
// Top level of the pulse flow totalizer: event decode, totalizer state and
// the pipelined binary to BCD conversion of the displayed value.
// Depends on pft_pkg.
//
// Flow-meter totalizer. Each req transaction carries one event (sensor pulse,
// one-second tick, start, stop, clear, set display mode, load saved total)
// and produces exactly one rsp transaction. Throughput is one transaction per
// clock cycle while rsp_ready is high. Each result is registered in the entry
// register and then in each stage of the double-dabble BCD conversion, which
// shifts BITS_PER_STAGE bits of the displayed value per stage. The totalizer
// state itself updates in the cycle an event is taken, so back-to-back events
// always see the effect of the previous one. The conversion pipeline holds
// items when rsp_ready is low and collapses bubbles, so req_ready stays high
// while any stage is empty. The display shows the chosen quantity modulo
// 10^DIGITS, packed units-first into the 28-bit display field (digits above
// the field are dropped). Configuration writes on the csr port take effect
// at once and are meant for idle periods.
module pulse_flow_totalizer
   import pft_pkg::*;
#(
   parameter int DIGITS = DIGITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [2:0]            req_cmd,
   input  logic [1:0]            req_mode,
   input  logic [TOTAL_W-1:0]    req_load_value,

   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_save_request,
   output logic [TOTAL_W-1:0]    rsp_save_value,
   output logic                  rsp_display_valid,
   output logic [1:0]            rsp_display_mode,
   output logic [DISP_W-1:0]     rsp_display_digits,
   output logic [TALLY_W-1:0]    rsp_flow_rate,

   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int BCD_W = 4 * DIGITS;

   // One entry of the conversion pipeline; bin shifts out MSB-first into bcd.
   typedef struct packed {
      logic               save_request;
      logic [TOTAL_W-1:0] save_value;
      logic               display_valid;
      logic [1:0]         display_mode;
      logic [TALLY_W-1:0] flow_rate;
      logic [TOTAL_W-1:0] bin;
      logic [BCD_W-1:0]   bcd;
   } stage_type;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [CSR_DATA_W-1:0] save_threshold_ff;
   logic [PERIOD_W-1:0]   save_period_ff;
   logic [PERIOD_W-1:0]   update_period_ff;
   logic [PERIOD_W-1:0]   toggle_period_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         save_threshold_ff <= SAVE_THRESHOLD_RST;
         save_period_ff    <= SAVE_PERIOD_RST;
         update_period_ff  <= UPDATE_PERIOD_RST;
         toggle_period_ff  <= TOGGLE_PERIOD_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_SAVE_THRESHOLD: save_threshold_ff <= csr_wdata;
            CSR_SAVE_PERIOD:    save_period_ff    <= csr_wdata[PERIOD_W-1:0];
            CSR_UPDATE_PERIOD:  update_period_ff  <= csr_wdata[PERIOD_W-1:0];
            CSR_TOGGLE_PERIOD:  toggle_period_ff  <= csr_wdata[PERIOD_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Totalizer state
   // ---------------------------------------------------------------------
   logic [TALLY_W-1:0]  pulse_tally_ff,       pulse_tally_in;
   logic [TALLY_W-1:0]  rate_latch_ff,        rate_latch_in;
   logic [TOTAL_W-1:0]  total_volume_ff,      total_volume_in;
   logic [TOTAL_W-1:0]  last_saved_ff,        last_saved_in;
   logic                running_ff,           running_in;
   logic                total_dirty_ff,       total_dirty_in;
   logic [1:0]          start_delay_ff,       start_delay_in;
   logic [PERIOD_W-1:0] save_tick_count_ff,   save_tick_count_in;
   logic [PERIOD_W-1:0] update_tick_count_ff, update_tick_count_in;
   logic [PERIOD_W-1:0] toggle_count_ff,      toggle_count_in;
   logic [1:0]          shown_mode_ff,        shown_mode_in;

   logic                accept;
   logic                refresh;      // display refresh due for this transaction
   logic                save;
   stage_type           entry;        // what the accepted transaction loads

   assign accept = req_valid && req_ready;

   always_comb begin
      logic [TOTAL_W-1:0] sum;
      logic [TOTAL_W-1:0] unsaved;

      pulse_tally_in       = pulse_tally_ff;
      rate_latch_in        = rate_latch_ff;
      total_volume_in      = total_volume_ff;
      last_saved_in        = last_saved_ff;
      running_in           = running_ff;
      total_dirty_in       = total_dirty_ff;
      start_delay_in       = start_delay_ff;
      save_tick_count_in   = save_tick_count_ff;
      update_tick_count_in = update_tick_count_ff;
      toggle_count_in      = toggle_count_ff;
      shown_mode_in        = shown_mode_ff;
      refresh              = 1'b0;
      save                 = 1'b0;
      sum                  = total_volume_ff + TOTAL_W'(pulse_tally_ff);
      unsaved              = sum - last_saved_ff;

      case (cmd_type'(req_cmd))
         CMD_PULSE: begin
            pulse_tally_in = pulse_tally_ff + TALLY_W'(1);
         end
         CMD_TICK: begin
            // Start delay expiry asks for a second refresh after a start.
            if (start_delay_ff != 2'd0) begin
               start_delay_in = start_delay_ff - 2'd1;
               if (start_delay_ff == 2'd1) begin
                  refresh = 1'b1;
               end
            end
            update_tick_count_in = update_tick_count_ff + PERIOD_W'(1);
            if (update_tick_count_in >= update_period_ff) begin
               update_tick_count_in = '0;
               // Update interval: while running, latch the rate and add it to the total.
               if (running_ff) begin
                  rate_latch_in = pulse_tally_ff;
                  if (pulse_tally_ff != '0) begin
                     total_volume_in = sum;
                     total_dirty_in  = 1'b1;
                     if (unsaved >= TOTAL_W'(save_threshold_ff)) begin
                        save           = 1'b1;
                        last_saved_in  = sum;
                        total_dirty_in = 1'b0;
                     end
                  end
               end
               // Periodic save check, only when the total has moved.
               save_tick_count_in = save_tick_count_ff + PERIOD_W'(1);
               if (save_tick_count_in >= save_period_ff) begin
                  save_tick_count_in = '0;
                  if (total_dirty_in) begin
                     save           = 1'b1;
                     last_saved_in  = total_volume_in;
                     total_dirty_in = 1'b0;
                  end
               end
               pulse_tally_in = '0;
               refresh        = 1'b1;
            end
            // Alternate between rate and total while running.
            if (running_ff) begin
               toggle_count_in = toggle_count_ff + PERIOD_W'(1);
               if (toggle_count_in >= toggle_period_ff) begin
                  toggle_count_in = '0;
                  shown_mode_in   = (shown_mode_ff == MODE_RATE) ? MODE_TOTAL : MODE_RATE;
                  refresh         = 1'b1;
               end
            end
         end
         CMD_START: begin
            if (!running_ff) begin
               pulse_tally_in = '0;
               rate_latch_in  = '0;
               running_in     = 1'b1;
               start_delay_in = START_DELAY_TICKS;
               refresh        = 1'b1;
            end
         end
         CMD_STOP: begin
            running_in = 1'b0;
         end
         CMD_CLEAR: begin
            pulse_tally_in = '0;
            rate_latch_in  = '0;
         end
         CMD_SET_MODE: begin
            shown_mode_in = req_mode;
            refresh       = 1'b1;
         end
         CMD_LOAD: begin
            total_volume_in = req_load_value;
            last_saved_in   = req_load_value;
            total_dirty_in  = 1'b0;
         end
         default: ;
      endcase

      // Result of this transaction, before BCD conversion.
      entry.save_request  = save;
      entry.save_value    = save ? total_volume_in : '0;
      entry.display_valid = refresh &&
                            (shown_mode_in == MODE_RATE || shown_mode_in == MODE_TOTAL);
      entry.display_mode  = entry.display_valid ? shown_mode_in : MODE_OFF;
      entry.flow_rate     = rate_latch_in;
      entry.bcd           = '0;
      if (!entry.display_valid) begin
         entry.bin = '0;
      end else if (shown_mode_in == MODE_RATE) begin
         entry.bin = TOTAL_W'(rate_latch_in);
      end else begin
         entry.bin = total_volume_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_tally_ff       <= '0;
         rate_latch_ff        <= '0;
         total_volume_ff      <= '0;
         last_saved_ff        <= '0;
         running_ff           <= 1'b0;
         total_dirty_ff       <= 1'b0;
         start_delay_ff       <= '0;
         save_tick_count_ff   <= '0;
         update_tick_count_ff <= '0;
         toggle_count_ff      <= '0;
         shown_mode_ff        <= MODE_OFF;
      end else if (accept) begin
         pulse_tally_ff       <= pulse_tally_in;
         rate_latch_ff        <= rate_latch_in;
         total_volume_ff      <= total_volume_in;
         last_saved_ff        <= last_saved_in;
         running_ff           <= running_in;
         total_dirty_ff       <= total_dirty_in;
         start_delay_ff       <= start_delay_in;
         save_tick_count_ff   <= save_tick_count_in;
         update_tick_count_ff <= update_tick_count_in;
         toggle_count_ff      <= toggle_count_in;
         shown_mode_ff        <= shown_mode_in;
      end
   end

   // ---------------------------------------------------------------------
   // Conversion pipeline: stage 0 is the entry register, the last stage is
   // the rsp output register. Each stage has its own load enable so empty
   // stages fill while later ones are stalled.
   // ---------------------------------------------------------------------
   stage_type stage_ff [0:CONV_STAGES];
   stage_type stage_in [1:CONV_STAGES];
   logic      valid_ff [0:CONV_STAGES];
   logic      load_en  [0:CONV_STAGES];

   always_comb begin
      load_en[CONV_STAGES] = !valid_ff[CONV_STAGES] || rsp_ready;
      for (int k = CONV_STAGES - 1; k >= 0; k--) begin
         load_en[k] = !valid_ff[k] || load_en[k+1];
      end
   end

   assign req_ready = load_en[0];

   // Double dabble: per shifted bit, add three to every digit of five or more.
   always_comb begin
      for (int k = 1; k <= CONV_STAGES; k++) begin
         stage_in[k] = stage_ff[k-1];
         for (int b = 0; b < BITS_PER_STAGE; b++) begin
            for (int d = 0; d < DIGITS; d++) begin
               if (stage_in[k].bcd[4*d +: 4] >= 4'd5) begin
                  stage_in[k].bcd[4*d +: 4] = stage_in[k].bcd[4*d +: 4] + 4'd3;
               end
            end
            stage_in[k].bcd = {stage_in[k].bcd[BCD_W-2:0], stage_in[k].bin[TOTAL_W-1]};
            stage_in[k].bin = {stage_in[k].bin[TOTAL_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= CONV_STAGES; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else begin
         if (load_en[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int k = 1; k <= CONV_STAGES; k++) begin
            if (load_en[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_en[0]) begin
         stage_ff[0] <= entry;
      end
      for (int k = 1; k <= CONV_STAGES; k++) begin
         if (load_en[k]) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   // ---------------------------------------------------------------------
   // rsp channel
   // ---------------------------------------------------------------------
   assign rsp_valid          = valid_ff[CONV_STAGES];
   assign rsp_save_request   = stage_ff[CONV_STAGES].save_request;
   assign rsp_save_value     = stage_ff[CONV_STAGES].save_value;
   assign rsp_display_valid  = stage_ff[CONV_STAGES].display_valid;
   assign rsp_display_mode   = stage_ff[CONV_STAGES].display_mode;
   assign rsp_display_digits = DISP_W'(stage_ff[CONV_STAGES].bcd);
   assign rsp_flow_rate      = stage_ff[CONV_STAGES].flow_rate;

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for pulse_flow_totalizer: directed event script, then
// random event streams under six register settings, all scored against a predictor.
// Depends on pft_pkg and the pulse_flow_totalizer RTL.
module tb;
   import pft_pkg::*;

   // Request codes outside the package enums, used for corner cases.
   localparam logic [2:0] CMD_SPARE  = 3'd7;   // unused event code, ignored by the block
   localparam logic [1:0] MODE_SPARE = 2'd3;   // stored as given, shows nothing

   // Pipeline depth: the entry register plus the conversion stages; the drain waits a bit past it.
   localparam int PIPE_LAT    = 1 + CONV_STAGES;
   localparam int DRAIN_EXTRA = PIPE_LAT + 4;

   // One result transaction, field order matches the rsp_ ports.
   typedef struct packed {
      logic        save_req;
      logic [31:0] save_val;
      logic        disp_valid;
      logic [1:0]  disp_mode;
      logic [27:0] digits;
      logic [15:0] rate;
   } flow_result_type;

   localparam flow_result_type NO_SHOW = '0;

   // Directed script row. Rows with typed set carry their expected result;
   // the rest are scored by the predictor.
   typedef struct packed {
      logic [2:0]      cmd;
      logic [1:0]      mode;
      logic [31:0]     load;
      logic            typed;
      flow_result_type want;
   } script_row_type;

   localparam int NUM_ROWS = 24;
   localparam script_row_type SCRIPT [NUM_ROWS] = '{
      // pulse after reset: nothing to show, rate still zero
      '{CMD_PULSE,    MODE_OFF,   32'h0000_0000, 1'b1, NO_SHOW},
      '{CMD_SET_MODE, MODE_TOTAL, 32'h0000_0000, 1'b1,
        '{1'b0, 32'd0, 1'b1, MODE_TOTAL, 28'h0, 16'd0}},
      // tick while stopped: rate latch holds, total unchanged, refresh shown
      '{CMD_TICK,     MODE_OFF,   32'h0000_0000, 1'b1,
        '{1'b0, 32'd0, 1'b1, MODE_TOTAL, 28'h0, 16'd0}},
      '{CMD_LOAD,     MODE_OFF,   32'hFFFF_FFFF, 1'b1, NO_SHOW},
      // all-ones total shown modulo ten million
      '{CMD_SET_MODE, MODE_TOTAL, 32'h0000_0000, 1'b1,
        '{1'b0, 32'd0, 1'b1, MODE_TOTAL, 28'h4967295, 16'd0}},
      '{CMD_START,    MODE_OFF,   32'h0000_0000, 1'b1,
        '{1'b0, 32'd0, 1'b1, MODE_TOTAL, 28'h4967295, 16'd0}},
      // start while running is ignored
      '{CMD_START,    MODE_OFF,   32'h0000_0000, 1'b1, NO_SHOW},
      '{CMD_PULSE,    MODE_OFF,   32'h0000_0000, 1'b0, NO_SHOW},
      '{CMD_PULSE,    MODE_RATE,  32'h0000_0000, 1'b0, NO_SHOW},
      '{CMD_PULSE,    MODE_OFF,   32'h0000_0000, 1'b0, NO_SHOW},
      // total wraps past all-ones, then start delay runs out, then a toggle
      '{CMD_TICK,     MODE_OFF,   32'h0000_0000, 1'b0, NO_SHOW},
      '{CMD_TICK,     MODE_OFF,   32'h0000_0000, 1'b0, NO_SHOW},
      '{CMD_TICK,     MODE_OFF,   32'h0000_0000, 1'b0, NO_SHOW},
      '{CMD_SET_MODE, MODE_SPARE, 32'h0000_0000, 1'b0, NO_SHOW},
      '{CMD_SPARE,    MODE_RATE,  32'hA5A5_5A5A, 1'b0, NO_SHOW},
      '{CMD_SET_MODE, MODE_RATE,  32'h0000_0000, 1'b0, NO_SHOW},
      '{CMD_PULSE,    MODE_OFF,   32'h0000_0000, 1'b0, NO_SHOW},
      '{CMD_STOP,     MODE_OFF,   32'h0000_0000, 1'b0, NO_SHOW},
      // pulse while stopped is counted, then dropped at the next update interval
      '{CMD_PULSE,    MODE_OFF,   32'h0000_0000, 1'b0, NO_SHOW},
      '{CMD_TICK,     MODE_OFF,   32'h0000_0000, 1'b0, NO_SHOW},
      '{CMD_CLEAR,    MODE_OFF,   32'h0000_0000, 1'b0, NO_SHOW},
      '{CMD_SET_MODE, MODE_OFF,   32'h0000_0000, 1'b1, NO_SHOW},
      '{CMD_LOAD,     MODE_OFF,   32'h0000_0000, 1'b1, NO_SHOW},
      '{CMD_SET_MODE, MODE_TOTAL, 32'h0000_0000, 1'b1,
        '{1'b0, 32'd0, 1'b1, MODE_TOTAL, 28'h0, 16'd0}}
   };

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [2:0]            req_cmd;
   logic [1:0]            req_mode;
   logic [TOTAL_W-1:0]    req_load_value;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_save_request;
   logic [TOTAL_W-1:0]    rsp_save_value;
   logic                  rsp_display_valid;
   logic [1:0]            rsp_display_mode;
   logic [DISP_W-1:0]     rsp_display_digits;
   logic [TALLY_W-1:0]    rsp_flow_rate;
   logic                  csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   pulse_flow_totalizer u_top (.*);

   always #1 clock = ~clock;

   // Predictor copy of the totalizer state and its registers.
   logic [15:0] cfg_threshold;
   logic [7:0]  cfg_save_period, cfg_update_period, cfg_toggle_period;
   logic [15:0] tally, rate;
   logic [31:0] total, saved_mark;
   logic        run_on, refresh_due, dirty;
   logic [1:0]  start_ticks;
   logic [7:0]  save_ticks, update_ticks, toggle_ticks;
   logic [1:0]  disp_sel;

   flow_result_type pending_q [$];   // expected results, oldest first
   bit              gaps_on;         // random idling on both channels
   logic            row_typed;       // sideband for the transaction on the req port
   flow_result_type row_want;
   int              fails, checked, saves_seen, shows_seen;

   // Seven packed BCD digits, units first; higher digits fall off.
   function automatic logic [27:0] bcd_pack(input logic [31:0] value);
      logic [27:0] packed_digits;
      packed_digits = '0;
      for (int d = 0; d < 7; d++) begin
         packed_digits[4*d +: 4] = 4'(value % 10);
         value = value / 10;
      end
      return packed_digits;
   endfunction

   // Advance the predictor by one event and return the result it produces.
   function automatic flow_result_type step_totalizer(input logic [2:0] cmd,
                                                      input logic [1:0] mode,
                                                      input logic [31:0] load);
      flow_result_type res;
      res = '0;
      case (cmd)
         CMD_PULSE: tally = tally + 16'd1;
         CMD_TICK: begin
            if (start_ticks != 2'd0) begin
               start_ticks = start_ticks - 2'd1;
               if (start_ticks == 2'd0) refresh_due = 1'b1;
            end
            update_ticks = update_ticks + 8'd1;
            if (update_ticks >= cfg_update_period) begin
               update_ticks = '0;
               if (run_on) begin
                  rate = tally;
                  if (rate != 16'd0) begin
                     total = total + {16'h0000, rate};
                     dirty = 1'b1;
                     // threshold works on the wrapped difference
                     if (total - saved_mark >= {16'h0000, cfg_threshold}) begin
                        res.save_req = 1'b1;
                        res.save_val = total;
                        saved_mark   = total;
                        dirty        = 1'b0;
                     end
                  end
               end
               save_ticks = save_ticks + 8'd1;
               if (save_ticks >= cfg_save_period) begin
                  save_ticks = '0;
                  if (dirty) begin
                     res.save_req = 1'b1;
                     res.save_val = total;
                     saved_mark   = total;
                     dirty        = 1'b0;
                  end
               end
               tally       = '0;
               refresh_due = 1'b1;
            end
            if (run_on) begin
               toggle_ticks = toggle_ticks + 8'd1;
               if (toggle_ticks >= cfg_toggle_period) begin
                  toggle_ticks = '0;
                  disp_sel     = (disp_sel == MODE_RATE) ? MODE_TOTAL : MODE_RATE;
                  refresh_due  = 1'b1;
               end
            end
         end
         CMD_START: begin
            if (!run_on) begin
               tally       = '0;
               rate        = '0;
               run_on      = 1'b1;
               refresh_due = 1'b1;
               start_ticks = START_DELAY_TICKS;
            end
         end
         CMD_STOP: run_on = 1'b0;
         CMD_CLEAR: begin
            tally = '0;
            rate  = '0;
         end
         CMD_SET_MODE: begin
            disp_sel    = mode;
            refresh_due = 1'b1;
         end
         CMD_LOAD: begin
            total      = load;
            saved_mark = load;
            dirty      = 1'b0;
         end
         default: ;
      endcase
      // a pending refresh is always consumed, shown only for rate or total
      if (refresh_due) begin
         refresh_due = 1'b0;
         if (disp_sel == MODE_RATE || disp_sel == MODE_TOTAL) begin
            res.disp_valid = 1'b1;
            res.disp_mode  = disp_sel;
            res.digits     = bcd_pack(disp_sel == MODE_RATE ? {16'h0000, rate} : total);
         end
      end
      res.rate = rate;
      return res;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         fails++;
      end
   endtask

   // Scoreboard: scores rsp transactions, feeds accepted req transactions to
   // the predictor and mirrors register writes. Everything is sampled at the
   // rising edge, before the design's updates land.
   always @(posedge clock) begin : scoreboard
      flow_result_type got, want;
      if (reset) begin
         cfg_threshold     = SAVE_THRESHOLD_RST;
         cfg_save_period   = SAVE_PERIOD_RST;
         cfg_update_period = UPDATE_PERIOD_RST;
         cfg_toggle_period = TOGGLE_PERIOD_RST;
         tally        = '0;
         rate         = '0;
         total        = '0;
         saved_mark   = '0;
         run_on       = 1'b0;
         refresh_due  = 1'b0;
         dirty        = 1'b0;
         start_ticks  = '0;
         save_ticks   = '0;
         update_ticks = '0;
         toggle_ticks = '0;
         disp_sel     = MODE_OFF;
      end else begin
         // score first: a result never comes back in the cycle its request goes in
         if (rsp_valid && rsp_ready) begin
            got = {rsp_save_request, rsp_save_value, rsp_display_valid,
                   rsp_display_mode, rsp_display_digits, rsp_flow_rate};
            if (pending_q.size() == 0) begin
               $error("result transaction with no expectation waiting");
               fails++;
            end else begin
               want = pending_q.pop_front();
               check_field("save_request",   32'(want.save_req),   32'(got.save_req));
               check_field("save_value",     want.save_val,        got.save_val);
               check_field("display_valid",  32'(want.disp_valid), 32'(got.disp_valid));
               check_field("display_mode",   32'(want.disp_mode),  32'(got.disp_mode));
               check_field("display_digits", 32'(want.digits),     32'(got.digits));
               check_field("flow_rate",      32'(want.rate),       32'(got.rate));
               checked++;
               if (got.save_req) saves_seen++;
               if (got.disp_valid) shows_seen++;
            end
         end
         if (req_valid && req_ready) begin
            want = step_totalizer(req_cmd, req_mode, req_load_value);
            pending_q.push_back(row_typed ? row_want : want);
         end
         if (csr_write_en) begin
            case (csr_index)
               CSR_SAVE_THRESHOLD: cfg_threshold     = csr_wdata;
               CSR_SAVE_PERIOD:    cfg_save_period   = csr_wdata[7:0];
               CSR_UPDATE_PERIOD:  cfg_update_period = csr_wdata[7:0];
               CSR_TOGGLE_PERIOD:  cfg_toggle_period = csr_wdata[7:0];
               default: ;
            endcase
         end
      end
   end

   // Result sink: stalls in random bursts while gaps are enabled.
   initial begin : rsp_sink
      int stall_left;
      stall_left = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            rsp_ready  <= 1'b0;
            stall_left = $urandom_range(0, 3);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Present one event and hold it until the transaction is taken. An idle
   // burst, if any, drops valid first; valid stays high between back-to-back events.
   task automatic push_event(input logic [2:0] cmd, input logic [1:0] mode,
                             input logic [31:0] load, input logic typed,
                             input flow_result_type want);
      @(negedge clock);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_cmd        <= cmd;
      req_mode       <= mode;
      req_load_value <= load;
      row_typed      = typed;
      row_want       = want;
      do @(posedge clock); while (!req_ready);
   endtask

   // Random event stream. It opens with a start so most of it runs the meter;
   // pulses and ticks dominate, stops are rare and restarts follow soon.
   task automatic run_random(input int count);
      logic [2:0]  cmd;
      logic [31:0] load;
      int          pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (n == 0)         cmd = CMD_START;
         else if (pick < 45) cmd = CMD_PULSE;
         else if (pick < 70) cmd = CMD_TICK;
         else if (pick < 75) cmd = CMD_START;
         else if (pick < 79) cmd = CMD_STOP;
         else if (pick < 82) cmd = CMD_CLEAR;
         else if (pick < 90) cmd = CMD_SET_MODE;
         else if (pick < 97) cmd = CMD_LOAD;
         else                cmd = CMD_SPARE;
         // near-top loads make the 32-bit total wrap soon after
         case ($urandom_range(0, 3))
            0:       load = $urandom_range(0, 2000);
            1:       load = 32'hFFFF_FF00 | $urandom_range(0, 255);
            default: load = $urandom();
         endcase
         push_event(cmd, 2'($urandom_range(0, 3)), load, 1'b0, NO_SHOW);
      end
   endtask

   // Register writes back to back; only called with the block idle.
   task automatic program_regs(input logic [15:0] threshold,
                               input logic [7:0] save_per, upd_per, tog_per);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_SAVE_THRESHOLD;
      csr_wdata    <= threshold;
      @(negedge clock);
      csr_index    <= CSR_SAVE_PERIOD;
      csr_wdata    <= {8'h00, save_per};
      @(negedge clock);
      csr_index    <= CSR_UPDATE_PERIOD;
      csr_wdata    <= {8'h00, upd_per};
      @(negedge clock);
      csr_index    <= CSR_TOGGLE_PERIOD;
      csr_wdata    <= {8'h00, tog_per};
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Drop valid, wait for every expected result, then let the pipe empty.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (DRAIN_EXTRA) @(posedge clock);
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_cmd        = CMD_PULSE;
      req_mode       = MODE_OFF;
      req_load_value = '0;
      csr_write_en   = 1'b0;
      csr_index      = CSR_SAVE_THRESHOLD;
      csr_wdata      = '0;
      row_typed      = 1'b0;
      row_want       = NO_SHOW;
      gaps_on        = 1'b1;
      fails          = 0;
      checked        = 0;
      saves_seen     = 0;
      shows_seen     = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed script under reset register values, then random traffic
      foreach (SCRIPT[i])
         push_event(SCRIPT[i].cmd, SCRIPT[i].mode, SCRIPT[i].load,
                    SCRIPT[i].typed, SCRIPT[i].want);
      run_random(100);
      settle();

      // smallest legal periods: save on every latch, toggle every tick
      program_regs(16'd1, 8'd1, 8'd1, 8'd1);
      run_random(120);
      settle();

      // largest values: latches and toggles almost never fire
      program_regs(16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
      run_random(100);
      settle();

      // all zero: every period fires on each tick, any added volume saves
      program_regs(16'd0, 8'd0, 8'd0, 8'd0);
      run_random(100);
      settle();

      // mid-range settings so rates build over several ticks
      program_regs(16'($urandom_range(10, 120)), 8'($urandom_range(2, 6)),
                   8'($urandom_range(1, 4)), 8'($urandom_range(1, 5)));
      run_random(140);
      settle();

      // back to reset values, full rate on both channels
      gaps_on = 1'b0;
      program_regs(SAVE_THRESHOLD_RST, SAVE_PERIOD_RST, UPDATE_PERIOD_RST,
                   TOGGLE_PERIOD_RST);
      run_random(140);
      settle();

      $display("Scored %0d transactions: %0d scripted events, then random streams under",
               checked, NUM_ROWS);
      $display("six register settings (zero and all-ones included); %0d saves, %0d refreshes.",
               saves_seen, shows_seen);
      if (fails == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin
      #400000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
